FILE: sv/pwac_pkg.sv
package pwac_pkg;

   // field widths
   localparam int SampleWidth = 12;
   localparam int TickWidth   = 16;
   localparam int EventWidth  = 3;
   localparam int StatusWidth = 2;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 16;

   typedef logic [StatusWidth-1:0] status_type;
   typedef logic [EventWidth-1:0]  event_type;
   typedef logic [TickWidth-1:0]   tick_type;

   // status codes
   localparam status_type ST_IDLE  = 2'd0;
   localparam status_type ST_BOOT  = 2'd1;
   localparam status_type ST_ALARM = 2'd2;
   localparam status_type ST_END   = 2'd3;

   // event codes
   localparam event_type EV_NONE  = 3'd0;
   localparam event_type EV_END   = 3'd1;
   localparam event_type EV_ALARM = 3'd2;
   localparam event_type EV_BOOT  = 3'd3;
   localparam event_type EV_CLEAR = 3'd4;
   localparam event_type EV_INIT  = 3'd5;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] REG_LEVEL_THRESHOLD  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_END_MIN_TICKS    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_ALARM_MIN_TICKS  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_START_MIN_TICKS  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_ALARM_HOLD_TICKS = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_BOOT_HOLD_TICKS  = 3'd5;

   // register reset values
   localparam logic [SampleWidth-1:0] LEVEL_THRESHOLD_RST  = 12'd1241;
   localparam tick_type               END_MIN_TICKS_RST    = 16'd300;
   localparam tick_type               ALARM_MIN_TICKS_RST  = 16'd150;
   localparam tick_type               START_MIN_TICKS_RST  = 16'd5;
   localparam tick_type               ALARM_HOLD_TICKS_RST = 16'd1200;
   localparam tick_type               BOOT_HOLD_TICKS_RST  = 16'd600;

   localparam tick_type TICK_MAX = '1;

   // event for a status change
   function automatic event_type event_for(input status_type status_new,
                                           input status_type status_old);
      event_type ev;
      ev = EV_NONE;
      case (status_new)
         ST_END:   ev = EV_END;
         ST_ALARM: ev = EV_ALARM;
         ST_BOOT:  ev = EV_BOOT;
         default: begin
            if (status_old == ST_ALARM) ev = EV_CLEAR;
            else if (status_old == ST_BOOT) ev = EV_INIT;
            else ev = EV_NONE;
         end
      endcase
      return ev;
   endfunction

endpackage

FILE: sv/pulse_width_alarm_classifier_unit.sv
// Pulse-width alarm classifier.
// One req_ word is one millisecond tick carrying a 12-bit converter sample.
// The sample is sliced against a threshold; edges latch the low and high
// pulse widths, and a falling edge classifies the high width into a status
// (idle, boot, alarm, end). Alarm and boot fall back to idle after a hold
// time without edges. A status change gives an event code on rsp_.
// Every accepted req_ word gives exactly one rsp_ word, in the next cycle.
// Throughput is one word per cycle: the whole tick is one compare/counter
// pass from the sample into the result register, and req_ready stays high
// whenever the result register is empty or being taken in the same cycle.
// If the receiver stalls, the result holds and req_ready drops until it goes.
// The csr_ channel, always ready, writes one of six threshold/hold registers
// by index; the user, not the block, sees that writes go in while it is idle.
// Synchronous reset restores the register defaults, clears pulse state to
// idle with zero widths and empties the result register.
module pulse_width_alarm_classifier_unit
   import pwac_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [SampleWidth-1:0]   req_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [EventWidth-1:0]    rsp_event_code,
   output logic [StatusWidth-1:0]   rsp_current_status,
   output logic                     rsp_led_drive,
   output logic [TickWidth-1:0]     rsp_last_high_width,
   output logic [TickWidth-1:0]     rsp_last_low_width,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIdxWidth-1:0]   csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   // configuration registers
   logic [SampleWidth-1:0] level_threshold_ff;
   tick_type end_min_ff, alarm_min_ff, start_min_ff, alarm_hold_ff, boot_hold_ff;

   // pulse state
   logic       prev_level_ff, prev_level_in;
   tick_type   elapsed_ff, elapsed_in;
   status_type status_ff, status_in;
   tick_type   high_width_ff, high_width_in;
   tick_type   low_width_ff, low_width_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   event_type  event_ff, event_in;

   logic       accept;
   logic       level;
   logic       rise, fall;
   tick_type   elapsed_edge;
   status_type status_class;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         level_threshold_ff <= LEVEL_THRESHOLD_RST;
         end_min_ff         <= END_MIN_TICKS_RST;
         alarm_min_ff       <= ALARM_MIN_TICKS_RST;
         start_min_ff       <= START_MIN_TICKS_RST;
         alarm_hold_ff      <= ALARM_HOLD_TICKS_RST;
         boot_hold_ff       <= BOOT_HOLD_TICKS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_LEVEL_THRESHOLD:  level_threshold_ff <= csr_wdata[SampleWidth-1:0];
            REG_END_MIN_TICKS:    end_min_ff         <= csr_wdata;
            REG_ALARM_MIN_TICKS:  alarm_min_ff       <= csr_wdata;
            REG_START_MIN_TICKS:  start_min_ff       <= csr_wdata;
            REG_ALARM_HOLD_TICKS: alarm_hold_ff      <= csr_wdata;
            REG_BOOT_HOLD_TICKS:  boot_hold_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // level slicing and edge detect
   assign level = (req_sample > level_threshold_ff);
   assign rise  = level && !prev_level_ff;
   assign fall  = !level && prev_level_ff;
   assign elapsed_edge = (rise || fall) ? '0 : elapsed_ff;

   // high pulse classification
   always_comb begin
      if (elapsed_ff > end_min_ff) status_class = ST_END;
      else if (elapsed_ff > alarm_min_ff && status_ff != ST_BOOT) status_class = ST_ALARM;
      else if (elapsed_ff > start_min_ff) status_class = ST_BOOT;
      else status_class = status_ff;
   end

   // next state for one tick
   always_comb begin
      status_in     = fall ? status_class : status_ff;
      high_width_in = fall ? elapsed_ff : high_width_ff;
      low_width_in  = rise ? elapsed_ff : low_width_ff;
      // hold timeouts
      if (status_in == ST_ALARM && elapsed_edge > alarm_hold_ff) status_in = ST_IDLE;
      if (status_in == ST_BOOT && elapsed_edge > boot_hold_ff) status_in = ST_IDLE;
      event_in      = (status_in != status_ff) ? event_for(status_in, status_ff) : EV_NONE;
      prev_level_in = level;
      elapsed_in    = (elapsed_edge != TICK_MAX) ? elapsed_edge + 1'b1 : elapsed_edge;
      rsp_valid_in  = accept || (rsp_valid_ff && !rsp_ready);
   end

   // state and result update
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b0;
         elapsed_ff    <= '0;
         status_ff     <= ST_IDLE;
         high_width_ff <= '0;
         low_width_ff  <= '0;
         event_ff      <= EV_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            prev_level_ff <= prev_level_in;
            elapsed_ff    <= elapsed_in;
            status_ff     <= status_in;
            high_width_ff <= high_width_in;
            low_width_ff  <= low_width_in;
            event_ff      <= event_in;
         end
      end
   end

   // state registers only change on accept, so they double as the result
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_code      = event_ff;
   assign rsp_current_status  = status_ff;
   assign rsp_led_drive       = !prev_level_ff;
   assign rsp_last_high_width = high_width_ff;
   assign rsp_last_low_width  = low_width_ff;

endmodule

FILE: sv/pwac_checker.sv
module pwac_checker
   import pwac_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [EventWidth-1:0]   rsp_event_code,
   input logic [StatusWidth-1:0]  rsp_current_status,
   input logic [TickWidth-1:0]    rsp_last_high_width
);

   // stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code)
         && $stable(rsp_current_status) && $stable(rsp_last_high_width))
      else $error("stalled result changed");

   // result valid in the cycle after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted word gave no result");

   // result register empties on reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // event code agrees with the status it reports
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == EV_CLEAR || rsp_event_code == EV_INIT)
         |-> rsp_current_status == ST_IDLE)
      else $error("clear event without idle status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == EV_END |-> rsp_current_status == ST_END)
      else $error("end event without end status");

endmodule

bind pulse_width_alarm_classifier_unit pwac_checker u_pwac_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_event_code      (rsp_event_code),
   .rsp_current_status  (rsp_current_status),
   .rsp_last_high_width (rsp_last_high_width)
);

FILE: test/testbench.sv
module testbench;
   import pwac_pkg::*;

   localparam int QUIET_LIMIT        = 2000;
   localparam int LONG_LOW_TICKS     = 24;
   localparam int PHASE_TICKS        = 72;
   localparam int PHASES             = 8;
   localparam int DIRECTED_THRESHOLD = 2047;
   localparam int RX_HOLD_CYCLES     = 64;

   // indexes past the last register, writes there change nothing
   localparam logic [CsrIdxWidth-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CsrIdxWidth-1:0] REG_SPARE_HI = 3'd7;

   // one result word as the block reports it
   typedef struct packed {
      event_type  ev;
      status_type status;
      logic       led;
      tick_type   high_w;
      tick_type   low_w;
   } class_word_type;

   // directed row: either a register write or a tick, optionally with a typed-in result
   typedef struct packed {
      logic                    is_write;
      logic [CsrIdxWidth-1:0]  index;
      logic [CsrDataWidth-1:0] value;
      logic                    pinned;
      class_word_type          word;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [SampleWidth-1:0]  req_sample = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [EventWidth-1:0]   rsp_event_code;
   logic [StatusWidth-1:0]  rsp_current_status;
   logic                    rsp_led_drive;
   logic [TickWidth-1:0]    rsp_last_high_width;
   logic [TickWidth-1:0]    rsp_last_low_width;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   // typed-in result travelling with the current req word
   logic           pinned_valid = 1'b0;
   class_word_type pinned_word = '0;

   // traffic shaping
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int rx_hold_asks = 0;
   int rx_hold_taken = 0;
   int rx_hold_cycles = 0;

   // predictor copy of the registers
   logic [SampleWidth-1:0] cfg_threshold;
   tick_type cfg_end_min, cfg_alarm_min, cfg_start_min, cfg_alarm_hold, cfg_boot_hold;

   // predictor copy of the pulse state
   logic       m_prev_level;
   tick_type   m_elapsed;
   status_type m_status;
   status_type m_status_seen;
   tick_type   m_high_w;
   tick_type   m_low_w;

   class_word_type expected_words [$];
   int mismatches = 0;
   int words_checked = 0;
   int ticks_taken = 0;
   int writes_taken = 0;
   int quiet_cycles = 0;
   int event_hits [8];

   pulse_width_alarm_classifier_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_code      (rsp_event_code),
      .rsp_current_status  (rsp_current_status),
      .rsp_led_drive       (rsp_led_drive),
      .rsp_last_high_width (rsp_last_high_width),
      .rsp_last_low_width  (rsp_last_low_width),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // one millisecond tick of the classifier, advances the predictor state
   function automatic class_word_type classify_tick(input logic [SampleWidth-1:0] smp);
      class_word_type w;
      logic           lvl;
      lvl = (smp > cfg_threshold);
      // edges latch the width of the pulse that just ended
      if (lvl && !m_prev_level) begin
         m_low_w   = m_elapsed;
         m_elapsed = '0;
      end else if (!lvl && m_prev_level) begin
         m_high_w  = m_elapsed;
         m_elapsed = '0;
         if (m_high_w > cfg_end_min) m_status = ST_END;
         else if (m_high_w > cfg_alarm_min && m_status != ST_BOOT) m_status = ST_ALARM;
         else if (m_high_w > cfg_start_min) m_status = ST_BOOT;
      end
      // hold timeouts, end never times out
      if (m_status == ST_ALARM && m_elapsed > cfg_alarm_hold) m_status = ST_IDLE;
      if (m_status == ST_BOOT && m_elapsed > cfg_boot_hold) m_status = ST_IDLE;
      // event only on a status change
      w.ev = EV_NONE;
      if (m_status != m_status_seen) begin
         case (m_status)
            ST_END:   w.ev = EV_END;
            ST_ALARM: w.ev = EV_ALARM;
            ST_BOOT:  w.ev = EV_BOOT;
            default: begin
               if (m_status_seen == ST_ALARM) w.ev = EV_CLEAR;
               else if (m_status_seen == ST_BOOT) w.ev = EV_INIT;
            end
         endcase
         m_status_seen = m_status;
      end
      m_prev_level = lvl;
      if (m_elapsed != TICK_MAX) m_elapsed = m_elapsed + 1'b1;
      w.status = m_status;
      w.led    = ~lvl;
      w.high_w = m_high_w;
      w.low_w  = m_low_w;
      return w;
   endfunction

   function automatic stim_row_type tick_row(input logic [SampleWidth-1:0] smp);
      stim_row_type r;
      r = '0;
      r.value = CsrDataWidth'(smp);
      return r;
   endfunction

   function automatic stim_row_type pinned_row(input logic [SampleWidth-1:0] smp,
                                               input event_type ev, input status_type st,
                                               input logic led, input tick_type hw,
                                               input tick_type lw);
      stim_row_type r;
      r = tick_row(smp);
      r.pinned = 1'b1;
      r.word = '{ev: ev, status: st, led: led, high_w: hw, low_w: lw};
      return r;
   endfunction

   function automatic stim_row_type reg_row(input logic [CsrIdxWidth-1:0] idx,
                                            input logic [CsrDataWidth-1:0] val);
      stim_row_type r;
      r = '0;
      r.is_write = 1'b1;
      r.index = idx;
      r.value = val;
      return r;
   endfunction

   // random sample on the wanted side of the threshold, low when none lies above it
   function automatic logic [SampleWidth-1:0] level_sample(input bit high, input int thr);
      if (high && thr < 4095) return SampleWidth'($urandom_range(4095, thr + 1));
      return SampleWidth'($urandom_range(thr, 0));
   endfunction

   // offer one sample word, valid stays up after acceptance until the next call decides
   task automatic send_tick(input logic [SampleWidth-1:0] smp, input bit pin,
                            input class_word_type pin_word);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_sample   <= smp;
      pinned_valid <= pin;
      pinned_word  <= pin_word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // csr valid stays up across a group of writes, caller lowers it
   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // stop offering and let every outstanding result word drain
   task automatic settle();
      req_valid    <= 1'b0;
      pinned_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // receiver: random stalls plus a long hold-off when asked
   always @(posedge clock) begin
      if (rx_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rx_hold_cycles <= rx_hold_cycles - 1;
      end else if (rx_hold_taken != rx_hold_asks) begin
         rsp_ready <= 1'b0;
         rx_hold_taken <= rx_hold_asks;
         rx_hold_cycles <= RX_HOLD_CYCLES - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // predict on req acceptance, compare on rsp acceptance
   always @(posedge clock) begin : scoreboard
      class_word_type got, want;
      if (reset) begin
         cfg_threshold  = LEVEL_THRESHOLD_RST;
         cfg_end_min    = END_MIN_TICKS_RST;
         cfg_alarm_min  = ALARM_MIN_TICKS_RST;
         cfg_start_min  = START_MIN_TICKS_RST;
         cfg_alarm_hold = ALARM_HOLD_TICKS_RST;
         cfg_boot_hold  = BOOT_HOLD_TICKS_RST;
         m_prev_level   = 1'b0;
         m_elapsed      = '0;
         m_status       = ST_IDLE;
         m_status_seen  = ST_IDLE;
         m_high_w       = '0;
         m_low_w        = '0;
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_LEVEL_THRESHOLD:  cfg_threshold  = csr_wdata[SampleWidth-1:0];
               REG_END_MIN_TICKS:    cfg_end_min    = csr_wdata;
               REG_ALARM_MIN_TICKS:  cfg_alarm_min  = csr_wdata;
               REG_START_MIN_TICKS:  cfg_start_min  = csr_wdata;
               REG_ALARM_HOLD_TICKS: cfg_alarm_hold = csr_wdata;
               REG_BOOT_HOLD_TICKS:  cfg_boot_hold  = csr_wdata;
               default: ;
            endcase
            writes_taken++;
         end
         if (req_valid && req_ready) begin
            want = classify_tick(req_sample);
            if (pinned_valid) want = pinned_word;
            expected_words = {expected_words, want};
            event_hits[want.ev]++;
            ticks_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            got.ev     = rsp_event_code;
            got.status = rsp_current_status;
            got.led    = rsp_led_drive;
            got.high_w = rsp_last_high_width;
            got.low_w  = rsp_last_low_width;
            words_checked++;
            if (expected_words.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected rsp word: ev=%0d st=%0d led=%0d hi=%0d lo=%0d",
                           got.ev, got.status, got.led, got.high_w, got.low_w);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               if (got.ev !== want.ev || got.status !== want.status || got.led !== want.led ||
                   got.high_w !== want.high_w || got.low_w !== want.low_w) begin
                  if (mismatches < 10) begin
                     $display("rsp word %0d expected: ev=%0d st=%0d led=%0d hi=%0d lo=%0d",
                              words_checked, want.ev, want.status, want.led, want.high_w,
                              want.low_w);
                     $display("rsp word %0d actual:   ev=%0d st=%0d led=%0d hi=%0d lo=%0d",
                              words_checked, got.ev, got.status, got.led, got.high_w,
                              got.low_w);
                  end
                  mismatches++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no handshake for %0d cycles, %0d words outstanding",
                  quiet_cycles, expected_words.size());
         $display("pulse_width_alarm_classifier_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      stim_row_type directed_rows [$];
      bit writing;
      int thr, lim_start, lim_alarm, lim_end, hold_alarm, hold_boot;
      int high_len, low_len, sent, n;
      writing = 1'b0;

      // reset values first, then tight limits so every status shows up in a few ticks
      directed_rows = '{
         pinned_row(12'd0,    EV_NONE, ST_IDLE, 1'b1, 16'd0, 16'd0),
         pinned_row(12'd4095, EV_NONE, ST_IDLE, 1'b0, 16'd0, 16'd1),
         // equal to the threshold counts as low, short high pulse keeps idle
         pinned_row(12'd1241, EV_NONE, ST_IDLE, 1'b1, 16'd1, 16'd1),
         pinned_row(12'd1242, EV_NONE, ST_IDLE, 1'b0, 16'd1, 16'd1),
         reg_row(REG_LEVEL_THRESHOLD,  {4'hF, 12'(DIRECTED_THRESHOLD)}),
         reg_row(REG_END_MIN_TICKS,    16'd4),
         reg_row(REG_ALARM_MIN_TICKS,  16'd2),
         reg_row(REG_START_MIN_TICKS,  16'd0),
         reg_row(REG_ALARM_HOLD_TICKS, 16'd1),
         reg_row(REG_BOOT_HOLD_TICKS,  16'd2),
         reg_row(REG_SPARE_LO,         16'hFFFF),
         reg_row(REG_SPARE_HI,         16'h0000),
         // falling edge into boot
         tick_row(12'd0),
         tick_row(12'd2048), tick_row(12'd4095), tick_row(12'd3000),
         // alarm-band width while boot stays boot
         tick_row(12'd2047),
         tick_row(12'd1000), tick_row(12'd12),
         // boot hold runs out
         tick_row(12'd2047),
         tick_row(12'd2500), tick_row(12'd4095), tick_row(12'd2048),
         // alarm, then its hold runs out
         tick_row(12'd0),
         tick_row(12'd1), tick_row(12'd2046),
         tick_row(12'd4095), tick_row(12'd2048), tick_row(12'd3333), tick_row(12'd4000),
         tick_row(12'd2222),
         // end, which never times out
         tick_row(12'd0),
         tick_row(12'd2047)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            if (!writing) settle();
            write_reg(directed_rows[i].index, directed_rows[i].value);
            writing = 1'b1;
         end else begin
            if (writing) csr_valid <= 1'b0;
            writing = 1'b0;
            send_tick(directed_rows[i].value[SampleWidth-1:0], directed_rows[i].pinned,
                      directed_rows[i].word);
         end
      end

      // long low stretch with no edges while in end
      repeat (LONG_LOW_TICKS) send_tick(level_sample(1'b0, DIRECTED_THRESHOLD), 1'b0, '0);
      send_tick(level_sample(1'b1, DIRECTED_THRESHOLD), 1'b0, '0);

      // random phases, each with its own limits and traffic shape
      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: begin
               thr = 0;
               lim_start = 0; lim_alarm = 0; lim_end = 0; hold_alarm = 0; hold_boot = 0;
            end
            1: begin
               thr = 4095;
               lim_start = 65535; lim_alarm = 65535; lim_end = 65535;
               hold_alarm = 65535; hold_boot = 65535;
            end
            default: begin
               thr = $urandom_range(4095);
               if (p == PHASES - 1) begin
                  // unordered limits
                  lim_start = $urandom_range(12);
                  lim_alarm = $urandom_range(12);
                  lim_end   = $urandom_range(12);
               end else begin
                  lim_start = $urandom_range(6);
                  lim_alarm = lim_start + $urandom_range(6);
                  lim_end   = lim_alarm + $urandom_range(8);
               end
               hold_alarm = $urandom_range(12);
               hold_boot  = $urandom_range(12);
            end
         endcase
         write_reg(REG_LEVEL_THRESHOLD,  {4'($urandom_range(15)), 12'(thr)});
         write_reg(REG_END_MIN_TICKS,    16'(lim_end));
         write_reg(REG_ALARM_MIN_TICKS,  16'(lim_alarm));
         write_reg(REG_START_MIN_TICKS,  16'(lim_start));
         write_reg(REG_ALARM_HOLD_TICKS, 16'(hold_alarm));
         write_reg(REG_BOOT_HOLD_TICKS,  16'(hold_boot));
         csr_valid <= 1'b0;

         case (p % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
            default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
         endcase
         // receiver backs off long enough for the input to stall
         if (p % 4 == 2) rx_hold_asks = rx_hold_asks + 1;

         sent = 0;
         while (sent < PHASE_TICKS) begin
            if ($urandom_range(99) < 85) begin
               // pulse width around one of the classification limits
               case ($urandom_range(2))
                  0:       high_len = lim_start;
                  1:       high_len = lim_alarm;
                  default: high_len = lim_end;
               endcase
               high_len = high_len + $urandom_range(2);
               if (high_len < 1) high_len = 1;
               if (high_len > 40) high_len = $urandom_range(40, 1);
               // gap around one of the hold times, or a short one
               case ($urandom_range(2))
                  0:       low_len = hold_alarm + $urandom_range(2);
                  1:       low_len = hold_boot + $urandom_range(2);
                  default: low_len = $urandom_range(3, 1);
               endcase
               if (low_len < 1) low_len = 1;
               if (low_len > 40) low_len = $urandom_range(40, 1);
               repeat (high_len) send_tick(level_sample(1'b1, thr), 1'b0, '0);
               repeat (low_len) send_tick(level_sample(1'b0, thr), 1'b0, '0);
               sent += high_len + low_len;
            end else begin
               // noise across the full sample range
               n = $urandom_range(8, 1);
               repeat (n) send_tick(SampleWidth'($urandom_range(4095)), 1'b0, '0);
               sent += n;
            end
         end
      end

      settle();
      repeat (4) @(posedge clock);
      mismatches += expected_words.size();

      $display("%0d ticks and %0d register writes accepted, %0d result words checked, %0d bad",
               ticks_taken, writes_taken, words_checked, mismatches);
      $display("events predicted: end %0d, alarm %0d, boot %0d, all clear %0d, initialized %0d",
               event_hits[EV_END], event_hits[EV_ALARM], event_hits[EV_BOOT],
               event_hits[EV_CLEAR], event_hits[EV_INIT]);
      if (mismatches == 0) begin
         $display("pulse_width_alarm_classifier_unit regression: pass");
      end else begin
         $display("pulse_width_alarm_classifier_unit regression: fail");
      end
      $finish;
   end

endmodule
